/* sv/sha256_pkg.sv */
// shared types, constants and round functions for the sha-256 hasher
// no dependencies; imported by every module of the block

package sha256_pkg;

	localparam int WORD_W = 32;
	localparam int WIN_D = 16;
	localparam int ROUNDS = 64;

	localparam logic [WORD_W-1:0] ROUND_K [ROUNDS] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [WORD_W-1:0] INIT_H [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam logic [5:0] LEN_FILL = 6'd56;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PAD,
		S_ROUND,
		S_UPDATE,
		S_OUT
	} state_t;

	typedef enum logic [2:0] {
		PH_NONE,
		PH_MARK,
		PH_ZERO,
		PH_LEN,
		PH_DONE
	} phase_t;

	typedef struct packed {
		logic       push;
		logic [7:0] push_byte;
		logic       sched_en;
		logic       sched_new;
		logic [5:0] rnd;
		logic       round_en;
		logic       vars_load;
		logic       chain_add;
		logic       chain_rot;
		logic       chain_init;
	} ctrl_t;

	function automatic logic [WORD_W-1:0] big_s0(input logic [WORD_W-1:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [WORD_W-1:0] big_s1(input logic [WORD_W-1:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [WORD_W-1:0] sml_s0(input logic [WORD_W-1:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [WORD_W-1:0] sml_s1(input logic [WORD_W-1:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
	endfunction

endpackage

/* sv/sha256_if.sv */
// valid/ready channel interfaces for message bytes and digest words
// no dependencies

interface sha256_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_value;
	logic       byte_present;
	logic       end_of_message;

	modport source (output valid, byte_value, byte_present, end_of_message, input ready);
	modport sink (input valid, byte_value, byte_present, end_of_message, output ready);
endinterface

interface sha256_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	modport source (output valid, digest_word, word_index, last_word, input ready);
	modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

/* sv/sha256_sched.sv */
// block buffer and message schedule window, one byte or one schedule word per cycle
// depends on sha256_pkg

module sha256_sched import sha256_pkg::*; (
	input  logic              clk,
	input  ctrl_t             ctrl,
	output logic [WORD_W-1:0] wk
);

	// word 15 is the oldest entry of the window
	logic [WIN_D-1:0][WORD_W-1:0] win_q;
	logic [WORD_W-1:0]            w_new;
	logic [WORD_W-1:0]            w_sel;
	logic [WORD_W-1:0]            wk_q;

	assign w_new = sml_s1(win_q[1]) + win_q[6] + sml_s0(win_q[14]) + win_q[15];
	assign w_sel = ctrl.sched_new ? w_new : win_q[15];

	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			win_q <= (WIN_D*WORD_W)'({win_q, ctrl.push_byte});
		end else if (ctrl.sched_en) begin
			win_q <= {win_q[WIN_D-2:0], w_sel};
			wk_q <= w_sel + ROUND_K[ctrl.rnd];
		end
	end

	assign wk = wk_q;

endmodule

/* sv/sha256_round.sv */
// working variables, one compression round per cycle, and the chaining words
// depends on sha256_pkg

module sha256_round import sha256_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  ctrl_t             ctrl,
	input  logic [WORD_W-1:0] wk,
	output logic [WORD_W-1:0] head_word
);

	logic [WORD_W-1:0] v_q [8];
	logic [WORD_W-1:0] chain_q [8];
	logic [WORD_W-1:0] t1;
	logic [WORD_W-1:0] t2;
	logic [WORD_W-1:0] ch;
	logic [WORD_W-1:0] mj;

	assign ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
	assign mj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
	assign t1 = v_q[7] + big_s1(v_q[4]) + ch + wk;
	assign t2 = big_s0(v_q[0]) + mj;

	always_ff @(posedge clk) begin
		if (ctrl.vars_load) begin
			for (int i = 0; i < 8; i++) begin
				v_q[i] <= chain_q[i];
			end
		end else if (ctrl.round_en) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				chain_q[i] <= INIT_H[i];
			end
		end else if (ctrl.chain_init) begin
			for (int i = 0; i < 8; i++) begin
				chain_q[i] <= INIT_H[i];
			end
		end else if (ctrl.chain_add) begin
			for (int i = 0; i < 8; i++) begin
				chain_q[i] <= chain_q[i] + v_q[i];
			end
		end else if (ctrl.chain_rot) begin
			for (int i = 0; i < 7; i++) begin
				chain_q[i] <= chain_q[i+1];
			end
			chain_q[7] <= chain_q[0];
		end
	end

	assign head_word = chain_q[0];

endmodule

/* sv/sha256_hasher.sv */
// sha-256 hasher top level: sequencer, byte count and padding
// depends on sha256_pkg, sha256_if, sha256_sched, sha256_round

// Message bytes enter one item per cycle while the block is not full. The item
// that completes a 64-byte block starts a compression that holds ready low:
// the rounds run through the single shared round unit (schedule word and round
// constant are added and registered ahead of the round), then the working
// variables are folded into the chaining words. An item with end_of_message
// then generates the padding one byte per cycle outside compressions (the 0x80
// marker, zeros up to byte 56, eight length bytes), which costs one or two
// compressions, and delivers the eight digest words h0 first, one per accepted
// output item. Items with neither a byte nor the end flag are taken and ignored.
// The block accepts no input until the eighth digest word is taken.

module sha256_hasher import sha256_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	sha256_in_if.sink   msg,
	sha256_out_if.source digest
);

	state_t       state_q, state_d;
	phase_t       phase_q, phase_d;
	logic [5:0]   fill_q, fill_d;
	logic [60:0]  msg_q, msg_d;
	logic [6:0]   rnd_q, rnd_d;
	logic [2:0]   len_cnt_q, len_cnt_d;
	logic [2:0]   oidx_q, oidx_d;
	ctrl_t        ctrl;
	logic [WORD_W-1:0] wk;
	logic [WORD_W-1:0] head_word;

	sha256_sched u_sched (
		.clk  (clk),
		.ctrl (ctrl),
		.wk   (wk)
	);

	sha256_round u_round (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.wk        (wk),
		.head_word (head_word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			phase_q   <= PH_NONE;
			fill_q    <= '0;
			msg_q     <= '0;
			rnd_q     <= '0;
			len_cnt_q <= '0;
			oidx_q    <= '0;
		end else begin
			state_q   <= state_d;
			phase_q   <= phase_d;
			fill_q    <= fill_d;
			msg_q     <= msg_d;
			rnd_q     <= rnd_d;
			len_cnt_q <= len_cnt_d;
			oidx_q    <= oidx_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		phase_d   = phase_q;
		fill_d    = fill_q;
		msg_d     = msg_q;
		rnd_d     = rnd_q;
		len_cnt_d = len_cnt_q;
		oidx_d    = oidx_q;
		ctrl      = '0;
		msg.ready = 1'b0;
		digest.valid = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				msg.ready = 1'b1;
				if (msg.valid) begin
					if (msg.byte_present) begin
						ctrl.push      = 1'b1;
						ctrl.push_byte = msg.byte_value;
						fill_d         = fill_q + 6'd1;
						msg_d          = msg_q + 61'd1;
					end
					if (msg.end_of_message) begin
						phase_d = PH_MARK;
					end
					if (msg.byte_present && fill_q == 6'd63) begin
						state_d        = S_ROUND;
						rnd_d          = '0;
						ctrl.vars_load = 1'b1;
					end else if (msg.end_of_message) begin
						state_d = S_PAD;
					end
				end
			end
			S_PAD: begin
				ctrl.push = 1'b1;
				fill_d    = fill_q + 6'd1;
				unique case (phase_q)
					PH_MARK: begin
						ctrl.push_byte = PAD_MARK;
						phase_d = (fill_d == LEN_FILL) ? PH_LEN : PH_ZERO;
					end
					PH_ZERO: begin
						ctrl.push_byte = 8'h00;
						phase_d = (fill_d == LEN_FILL) ? PH_LEN : PH_ZERO;
					end
					PH_LEN: begin
						// bit length goes out msb first, count shifted up a byte each time
						ctrl.push_byte = msg_q[60:53];
						msg_d     = {msg_q[52:0], 8'd0};
						len_cnt_d = len_cnt_q + 3'd1;
						if (len_cnt_q == 3'd7) begin
							phase_d = PH_DONE;
						end
					end
					default: begin
						ctrl.push = 1'b0;
						fill_d    = fill_q;
						state_d   = S_IDLE;
					end
				endcase
				if (ctrl.push && fill_q == 6'd63) begin
					state_d        = S_ROUND;
					rnd_d          = '0;
					ctrl.vars_load = 1'b1;
				end
			end
			S_ROUND: begin
				ctrl.sched_en  = (rnd_q != 7'(ROUNDS));
				ctrl.sched_new = (rnd_q >= 7'(WIN_D));
				ctrl.rnd       = rnd_q[5:0];
				ctrl.round_en  = (rnd_q != '0);
				rnd_d          = rnd_q + 7'd1;
				if (rnd_q == 7'(ROUNDS)) begin
					state_d = S_UPDATE;
					rnd_d   = '0;
				end
			end
			S_UPDATE: begin
				ctrl.chain_add = 1'b1;
				priority case (phase_q)
					PH_DONE: begin
						state_d = S_OUT;
						oidx_d  = '0;
					end
					PH_NONE: state_d = S_IDLE;
					default: state_d = S_PAD;
				endcase
			end
			S_OUT: begin
				digest.valid = 1'b1;
				if (digest.ready) begin
					ctrl.chain_rot = 1'b1;
					oidx_d = oidx_q + 3'd1;
					if (oidx_q == 3'd7) begin
						ctrl.chain_init = 1'b1;
						state_d   = S_IDLE;
						phase_d   = PH_NONE;
						fill_d    = '0;
						msg_d     = '0;
						len_cnt_d = '0;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign digest.digest_word = head_word;
	assign digest.word_index  = oidx_q;
	assign digest.last_word   = (oidx_q == 3'd7);

`ifndef SYNTH
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(msg.ready && digest.valid))
		else $error("input ready while digest item pending");

	a_round_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_ROUND |-> rnd_q <= 7'(ROUNDS))
		else $error("round counter past last round");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		digest.valid && digest.ready && digest.last_word |=> state_q == S_IDLE && fill_q == '0)
		else $error("block not reinitialized after last digest item");

	a_first_word: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(digest.valid) |-> digest.word_index == 3'd0)
		else $error("digest does not start at word zero");
`endif

endmodule

/* tb/sha256_hasher_test.sv */
`timescale 1ns / 1ps
// self-checking testbench for sha256_hasher: random message streams, digest checked per word
// depends on sha256_if and the sha256_hasher rtl

module sha256_hasher_test;

	localparam int RANDOM_ITEMS = 250;
	localparam int QUIET_LIMIT = 4000;
	localparam int TAIL_CYCLES = 50;

	localparam logic [31:0] ROUND_CONST [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] START_H [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	typedef struct {
		logic [7:0] value;
		logic       present;
		logic       eom;
		bit         hold_for_drain;
	} msg_item_t;

	typedef struct {
		logic [31:0] word;
		logic [2:0]  index;
		logic        last;
	} digest_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	sha256_in_if msg_ch();
	sha256_out_if dig_ch();

	sha256_hasher i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.msg(msg_ch),
		.digest(dig_ch)
	);

	always #1 clk = ~clk;

	msg_item_t pending [$];
	msg_item_t cur_item;
	digest_word_t digest_due [$];
	digest_word_t got_word;
	int total_items;
	int items_taken = 0;
	int words_due = 0;
	int words_seen = 0;
	int stall_pct = 81;
	int errors = 0;
	int quiet = 0;
	bit timed_out = 1'b0;

	// hash state of the predictor
	logic [31:0] chain_h [8];
	logic [7:0]  blk [64];
	int          fill;
	logic [60:0] msg_len;

	function automatic logic [31:0] ror(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic void compress_block();
		logic [31:0] w [64];
		logic [31:0] v [8];
		logic [31:0] t1, t2;
		for (int t = 0; t < 64; t++) begin
			if (t < 16)
				w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
			else
				w[t] = (ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7]
					+ (ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
		end
		v = chain_h;
		for (int t = 0; t < 64; t++) begin
			t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_CONST[t] + w[t];
			t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6];
			v[6] = v[5];
			v[5] = v[4];
			v[4] = v[3] + t1;
			v[3] = v[2];
			v[2] = v[1];
			v[1] = v[0];
			v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			chain_h[i] = chain_h[i] + v[i];
	endfunction

	function automatic void absorb(input logic [7:0] v);
		blk[fill] = v;
		fill++;
		if (fill == 64) begin
			compress_block();
			fill = 0;
		end
	endfunction

	function automatic void predict_digest(input msg_item_t it);
		logic [63:0] bit_len;
		digest_word_t dw;
		if (it.present) begin
			absorb(it.value);
			msg_len = msg_len + 61'd1;
		end
		if (!it.eom)
			return;
		bit_len = {msg_len, 3'b000};
		absorb(8'h80);
		if (fill > 56)
			while (fill != 0)
				absorb(8'h00);
		while (fill < 56)
			absorb(8'h00);
		for (int s = 56; s >= 0; s -= 8)
			absorb(bit_len[s +: 8]);
		for (int i = 0; i < 8; i++) begin
			dw.word = chain_h[i];
			dw.index = 3'(i);
			dw.last = (i == 7);
			digest_due.insert(digest_due.size(), dw);
		end
		words_due += 8;
		chain_h = START_H;
		fill = 0;
		msg_len = '0;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		errors++;
		$display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
	endtask

	task automatic add_item(input logic [7:0] v, input logic p, input logic e,
			input bit hold = 1'b0);
		msg_item_t it;
		it.value = v;
		it.present = p;
		it.eom = e;
		it.hold_for_drain = hold;
		pending.insert(pending.size(), it);
	endtask

	// random message; returns the number of items that carry a byte or the end
	task automatic add_message(input int len, input bit hold, output int counted);
		bit end_on_byte;
		end_on_byte = (len > 0) && ($urandom_range(1) == 1);
		for (int i = 0; i < len; i++) begin
			if (i > 0 && $urandom_range(19) == 0)
				add_item(8'($urandom_range(255)), 1'b0, 1'b0);
			add_item(8'($urandom_range(255)), 1'b1, end_on_byte && i == len - 1,
				hold && i == 0);
		end
		if (!end_on_byte)
			add_item(8'($urandom_range(255)), 1'b0, 1'b1, hold && len == 0);
		counted = len + (end_on_byte ? 0 : 1);
	endtask

	function automatic int phase_of(input int n);
		if (n < total_items / 3)
			return 0;
		if (n < 2 * total_items / 3)
			return 1;
		return 2;
	endfunction

	function automatic int send_idle_pct(input int n);
		case (phase_of(n))
			0: return 29;
			1: return 81;
			default: return 0;
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msg_ch.valid <= 1'b0;
			msg_ch.byte_value <= '0;
			msg_ch.byte_present <= 1'b0;
			msg_ch.end_of_message <= 1'b0;
		end else begin
			if (msg_ch.valid && msg_ch.ready) begin
				predict_digest(cur_item);
				items_taken++;
				case (phase_of(items_taken))
					0: stall_pct <= 81;
					1: stall_pct <= 29;
					default: stall_pct <= 0;
				endcase
			end
			if (!msg_ch.valid || msg_ch.ready) begin
				if (pending.size() != 0
						&& (!pending[0].hold_for_drain || words_due == words_seen)
						&& $urandom_range(99) >= send_idle_pct(items_taken)) begin
					cur_item = pending.pop_front();
					msg_ch.valid <= 1'b1;
					msg_ch.byte_value <= cur_item.value;
					msg_ch.byte_present <= cur_item.present;
					msg_ch.end_of_message <= cur_item.eom;
				end else begin
					msg_ch.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dig_ch.ready <= 1'b0;
		end else begin
			if (dig_ch.valid && dig_ch.ready) begin
				words_seen <= words_seen + 1;
				if (digest_due.size() == 0) begin
					report_mismatch("unexpected digest word", dig_ch.digest_word, '0);
				end else begin
					got_word = digest_due.pop_front();
					if (dig_ch.digest_word !== got_word.word)
						report_mismatch("digest_word", dig_ch.digest_word, got_word.word);
					if (dig_ch.word_index !== got_word.index)
						report_mismatch("word_index", 32'(dig_ch.word_index),
							32'(got_word.index));
					if (dig_ch.last_word !== got_word.last)
						report_mismatch("last_word", 32'(dig_ch.last_word),
							32'(got_word.last));
				end
			end
			dig_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if ((msg_ch.valid && msg_ch.ready) || (dig_ch.valid && dig_ch.ready))
				quiet <= 0;
			else
				quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT)
				timed_out <= 1'b1;
		end
	end

	initial begin
		int counted;
		int random_count;
		int pick;
		int len;
		chain_h = START_H;
		fill = 0;
		msg_len = '0;

		// ignored item, empty message, single bytes at the extremes
		add_item(8'hff, 1'b0, 1'b0);
		add_item(8'h00, 1'b0, 1'b1);
		add_item(8'h00, 1'b1, 1'b1);
		add_item(8'hff, 1'b1, 1'b0);
		add_item(8'h5a, 1'b0, 1'b0);
		add_item(8'ha5, 1'b0, 1'b1);
		// "abc"
		add_item(8'h61, 1'b1, 1'b0, 1'b1);
		add_item(8'h62, 1'b1, 1'b0);
		add_item(8'h63, 1'b1, 1'b1);
		// data bytes around the pad marker value, 0x80 itself among them
		add_item(8'h80, 1'b1, 1'b0);
		add_item(8'h7f, 1'b1, 1'b0);
		add_item(8'h01, 1'b1, 1'b0);
		add_item(8'hff, 1'b0, 1'b1);

		// random messages, lengths biased around the one/two block padding edge
		random_count = 0;
		while (random_count < RANDOM_ITEMS) begin
			pick = $urandom_range(99);
			if (pick < 45)
				len = $urandom_range(12);
			else if (pick < 80)
				len = $urandom_range(72, 52);
			else
				len = $urandom_range(140);
			if (len > RANDOM_ITEMS - random_count)
				len = RANDOM_ITEMS - random_count;
			add_message(len, random_count == 0 || $urandom_range(7) == 0, counted);
			random_count += counted;
		end
		total_items = pending.size();

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while ((pending.size() != 0 || msg_ch.valid || digest_due.size() != 0)
				&& !timed_out)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
		if (digest_due.size() != 0)
			report_mismatch("digest words never delivered", 32'(digest_due.size()), '0);
		if (timed_out || errors != 0) begin
			$display("CHECKS FAILED");
		end else begin
			$display("ALL CHECKS PASSED");
		end
		$finish;
	end

endmodule
